[rtl/plc_pkg.sv]
// Shared types, constants and reset values for the correction lookup.
package plc_pkg;

  localparam int FREQ_W      = 24;
  localparam int CORR_W      = 16;
  localparam int IDX_W       = 3;
  localparam int COUNT_W     = 4;
  localparam int FRAC_W      = 17;
  localparam int ACC_W       = 33;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CORR_W-1:0]  UNITY_CORR  = 16'd4096;
  localparam logic [FREQ_W-1:0]  TAIL_FREQ   = 24'd600000;
  localparam logic [FRAC_W-1:0]  FRAC_ONE    = 17'd65536;
  localparam logic [ACC_W-1:0]   ROUND_HALF  = 33'd32768;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  localparam logic [FREQ_W-1:0] RESET_FREQ [8] = '{
    24'd10000, 24'd50000, 24'd100000, 24'd200000,
    24'd300000, 24'd400000, 24'd500000, 24'd600000
  };

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SKIP,
    OP_QUERY
  } plc_op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_SETUP,
    BK_DIVIDE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_ROUND
  } plc_bk_state_t;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  point_index;
    logic [FREQ_W-1:0] point_frequency;
    logic [CORR_W-1:0] point_correction;
    logic [FREQ_W-1:0] query_frequency;
  } plc_in_t;

  typedef struct packed {
    logic [CORR_W-1:0] correction;
    logic              is_answer;
  } plc_out_t;

  typedef struct packed {
    plc_op_t           op;
    logic [IDX_W-1:0]  index;
    logic [FREQ_W-1:0] freq;
    logic [CORR_W-1:0] corr;
  } plc_item_t;

  function automatic logic [FREQ_W-1:0] reset_freq(input int i);
    logic [FREQ_W-1:0] f;
    if (i < 8) begin
      f = RESET_FREQ[i[2:0]];
    end else begin
      f = TAIL_FREQ;
    end
    return f;
  endfunction

endpackage

[rtl/plc_front.sv]
// Input stage: accepts requests, classifies them and hands them to the queue.
module plc_front import plc_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  plc_in_t   in_data,
  output logic      push,
  output plc_item_t push_item,
  input  logic      q_full
);

  logic      front_v_r, front_v_nxt;
  plc_item_t front_r;
  plc_item_t classified;
  logic      accept;

  assign in_stall  = front_v_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = front_v_r && !q_full;
  assign push_item = front_r;

  always_comb begin
    classified.index = in_data.point_index;
    classified.corr  = in_data.point_correction;
    if (in_data.req_type == REQ_QUERY) begin
      classified.op   = OP_QUERY;
      classified.freq = in_data.query_frequency;
    end else begin
      classified.freq = in_data.point_frequency;
      if (32'(in_data.point_index) < MAX_POINTS) begin
        classified.op = OP_WRITE;
      end else begin
        classified.op = OP_SKIP;
      end
    end
  end

  assign front_v_nxt = accept || (front_v_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_r <= classified;
    end
  end

endmodule

[rtl/plc_queue.sv]
// Short queue between the input stage and the execution engine.
module plc_queue import plc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  plc_item_t push_item,
  output logic      full,
  output logic      q_valid,
  output plc_item_t q_item,
  input  logic      pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  plc_item_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/plc_back.sv]
// Execution engine: point table, segment search, divider, blend and result register.
module plc_back import plc_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  plc_item_t          q_item,
  output logic               q_pop,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_count,
  output logic               out_valid,
  input  logic               out_stall,
  output plc_out_t           out_data
);

  localparam int IW     = $clog2(MAX_POINTS);
  localparam int NW     = IW + 1;
  localparam int STEP_W = $clog2(FRAC_W);

  logic [FREQ_W-1:0]  tbl_freq_r [MAX_POINTS];
  logic [CORR_W-1:0]  tbl_corr_r [MAX_POINTS];
  logic [COUNT_W-1:0] count_r;

  plc_bk_state_t state_r, state_nxt;

  logic [IW-1:0]     idx_r;
  logic [FREQ_W-1:0] qf_r;
  logic [FREQ_W-1:0] prev_f_r;
  logic [CORR_W-1:0] prev_c_r;
  logic [FREQ_W-1:0] f1_r;
  logic [CORR_W-1:0] c1_r;
  logic [FREQ_W-1:0] dvs_r;
  logic [FREQ_W-1:0] rem_r;
  logic [FRAC_W-1:0] quo_r;
  logic [STEP_W-1:0] step_r;
  logic [ACC_W-1:0]  acc_r;

  logic              out_valid_r, out_valid_nxt;
  plc_out_t          out_data_r;

  logic [NW-1:0]     n_used;
  logic [FREQ_W-1:0] e_freq;
  logic [CORR_W-1:0] e_corr;
  logic              hit, last, is_first, out_free;
  logic              tbl_we, res_load, res_answer;
  logic [CORR_W-1:0] res_corr;
  logic [IW-1:0]     wr_addr;

  logic [FREQ_W-1:0]         q_off, seg_d;
  logic [FREQ_W+FRAC_W-1:0]  num;
  logic [FREQ_W:0]           trial, diff;
  logic                      ge;
  logic [FREQ_W-1:0]         rem_nxt;
  logic [FRAC_W-1:0]         quo_nxt;
  logic [FRAC_W-1:0]         w0;
  logic [ACC_W-1:0]          prod_lo, prod_hi, rounded;

  always_comb begin
    if (32'(count_r) > MAX_POINTS) begin
      n_used = NW'(MAX_POINTS);
    end else begin
      n_used = NW'(count_r);
    end
  end

  assign e_freq   = tbl_freq_r[idx_r];
  assign e_corr   = tbl_corr_r[idx_r];
  assign hit      = (qf_r <= e_freq);
  assign last     = (NW'(idx_r) == n_used - NW'(1));
  assign is_first = (idx_r == '0);
  assign out_free = !out_valid_r || !out_stall;
  assign wr_addr  = IW'(q_item.index);

  assign q_off = qf_r - prev_f_r;
  assign seg_d = f1_r - prev_f_r;
  assign num   = {q_off, 16'b0} + (FREQ_W+FRAC_W)'(seg_d >> 1);

  assign trial   = {rem_r, quo_r[FRAC_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
  assign quo_nxt = {quo_r[FRAC_W-2:0], ge};

  assign w0      = FRAC_ONE - quo_r;
  assign prod_lo = ACC_W'(prev_c_r) * ACC_W'(w0);
  assign prod_hi = ACC_W'(c1_r) * ACC_W'(quo_r);
  assign rounded = acc_r + ROUND_HALF;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop && q_item.op == OP_QUERY && n_used != '0) begin
          state_nxt = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          state_nxt = is_first ? BK_IDLE : BK_SETUP;
        end else if (last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_SETUP:  state_nxt = BK_DIVIDE;
      BK_DIVIDE: begin
        if (step_r == STEP_W'(FRAC_W - 1)) begin
          state_nxt = BK_MUL_LO;
        end
      end
      BK_MUL_LO: state_nxt = BK_MUL_HI;
      BK_MUL_HI: state_nxt = BK_ROUND;
      BK_ROUND:  state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    tbl_we     = 1'b0;
    res_load   = 1'b0;
    res_corr   = '0;
    res_answer = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_WRITE: begin
              tbl_we   = 1'b1;
              res_load = 1'b1;
            end
            OP_SKIP: res_load = 1'b1;
            OP_QUERY: begin
              if (n_used == '0) begin
                res_load   = 1'b1;
                res_corr   = UNITY_CORR;
                res_answer = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_SEARCH: begin
        if ((hit && is_first) || (!hit && last)) begin
          res_load   = 1'b1;
          res_corr   = e_corr;
          res_answer = 1'b1;
        end
      end
      BK_ROUND: begin
        res_load   = 1'b1;
        res_corr   = rounded[CORR_W+15:16];
        res_answer = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        tbl_freq_r[i] <= reset_freq(i);
        tbl_corr_r[i] <= UNITY_CORR;
      end
    end else if (tbl_we) begin
      tbl_freq_r[wr_addr] <= q_item.freq;
      tbl_corr_r[wr_addr] <= q_item.corr;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r.correction <= res_corr;
      out_data_r.is_answer  <= res_answer;
    end
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          qf_r  <= q_item.freq;
          idx_r <= '0;
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          f1_r <= e_freq;
          c1_r <= e_corr;
        end else if (!last) begin
          prev_f_r <= e_freq;
          prev_c_r <= e_corr;
          idx_r    <= idx_r + 1'b1;
        end
      end
      BK_SETUP: begin
        dvs_r  <= seg_d;
        rem_r  <= num[FREQ_W+FRAC_W-1:FRAC_W];
        quo_r  <= num[FRAC_W-1:0];
        step_r <= '0;
      end
      BK_DIVIDE: begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        step_r <= step_r + 1'b1;
      end
      BK_MUL_LO: acc_r <= prod_lo;
      BK_MUL_HI: acc_r <= acc_r + prod_hi;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/piecewise_linear_correction_lookup.sv]
// Top level of the piecewise-linear gain correction lookup.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | plc_in_t  (write point or query)
//  out_    | output    | out_valid/out_stall | plc_out_t (answer or write ack)
//  cfg_    | input     | cfg_valid/cfg_ready | point_count, 4 bits
//
// Items execute one at a time in the back end. A query with no points in use is
// answered straight from the idle state; otherwise one table entry is scanned per
// cycle, and a hit past the first entry goes on to a setup step, a restoring divide
// of 17 quotient bits and the blend steps BK_MUL_LO, BK_MUL_HI and BK_ROUND.
// The front register and a 2-entry queue keep accepting while the back end works.
// Synchronous reset restores the default table and a point count of 8.
// The result register holds under out_stall; the back end starts an item only
// when that register is free.
module piecewise_linear_correction_lookup import plc_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plc_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output plc_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic      push, q_full, q_valid, q_pop;
  plc_item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  plc_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  plc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  plc_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_count (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/plc_checker.sv]
// Port-level checks for the correction lookup, bound to the top level.
module plc_checker import plc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input plc_in_t            in_data,
  input logic               out_valid,
  input logic               out_stall,
  input plc_out_t           out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_answer |-> out_data.correction == '0)
    else $error("write acknowledgement carries a nonzero correction");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind piecewise_linear_correction_lookup plc_checker u_plc_checker (.*);

[dv/piecewise_linear_correction_lookup_tb.sv]
// Testbench for the correction lookup: table writes and queries checked against a predictor.
module piecewise_linear_correction_lookup_tb import plc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE      = 8;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 60;

  localparam int PHASE_POINT_COUNT [PHASES] = '{15, 0, 1, 2, 5, 8, 3, 8};
  localparam int PHASE_TX_IDLE     [PHASES] = '{0, 57, 0, 38, 0, 57, 0, 38};
  localparam int PHASE_RX_STALL    [PHASES] = '{0, 0, 57, 38, 0, 0, 57, 38};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  plc_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  plc_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  plc_in_t  request_backlog[$];
  plc_out_t expected_answers[$];

  logic [FREQ_W-1:0]  model_freq [TABLE_SIZE];
  logic [CORR_W-1:0]  model_corr [TABLE_SIZE];
  logic [COUNT_W-1:0] model_count;
  logic [FREQ_W-1:0]  plan_freq [TABLE_SIZE];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_count = 0;
  logic hold_start = 1'b0;
  int mismatch_count = 0;

  always #1 clk = ~clk;

  piecewise_linear_correction_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [CORR_W-1:0] interpolated_correction(input logic [FREQ_W-1:0] q);
    int n;
    logic [63:0] c0, c1, d, frac, blend;
    n = (model_count > TABLE_SIZE) ? TABLE_SIZE : int'(model_count);
    if (n == 0) return UNITY_CORR;
    if (q <= model_freq[0]) return model_corr[0];
    for (int i = 1; i < n; i++) begin
      if (q <= model_freq[i]) begin
        if (model_freq[i] <= model_freq[i-1]) return model_corr[i];
        c0 = 64'(model_corr[i-1]);
        c1 = 64'(model_corr[i]);
        d = 64'(model_freq[i]) - 64'(model_freq[i-1]);
        frac = (((64'(q) - 64'(model_freq[i-1])) << 16) + (d >> 1)) / d;
        if (frac > 64'd65536) frac = 64'd65536;
        blend = (c0 * (64'd65536 - frac) + c1 * frac + 64'd32768) >> 16;
        return blend[CORR_W-1:0];
      end
    end
    return model_corr[n-1];
  endfunction

  function automatic void predict_answer(input plc_in_t r);
    plc_out_t e;
    if (r.req_type == REQ_WRITE) begin
      model_freq[r.point_index] = r.point_frequency;
      model_corr[r.point_index] = r.point_correction;
      e.correction = '0;
      e.is_answer = 1'b0;
    end else begin
      e.correction = interpolated_correction(r.query_frequency);
      e.is_answer = 1'b1;
    end
    expected_answers.push_back(e);
  endfunction

  function automatic plc_in_t write_item(input logic [IDX_W-1:0] idx,
                                         input logic [FREQ_W-1:0] f,
                                         input logic [CORR_W-1:0] c);
    plc_in_t r;
    logic [31:0] ra;
    ra = $urandom;
    r.req_type = REQ_WRITE;
    r.point_index = idx;
    r.point_frequency = f;
    r.point_correction = c;
    r.query_frequency = ra[FREQ_W-1:0];
    plan_freq[idx] = f;
    return r;
  endfunction

  function automatic plc_in_t query_item(input logic [FREQ_W-1:0] q);
    plc_in_t r;
    logic [31:0] ra, rb;
    ra = $urandom;
    rb = $urandom;
    r.req_type = REQ_QUERY;
    r.point_index = ra[IDX_W-1:0];
    r.point_frequency = rb[FREQ_W-1:0];
    r.point_correction = ra[31:16];
    r.query_frequency = q;
    return r;
  endfunction

  function automatic void plan_table();
    logic [31:0] f;
    logic [CORR_W-1:0] c;
    f = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(0, 5000));
    for (int i = 0; i < TABLE_SIZE; i++) begin
      c = ($urandom_range(1) == 0) ? 16'($urandom_range(3000, 5200)) : 16'($urandom);
      request_backlog.push_back(write_item(IDX_W'(i), f[FREQ_W-1:0], c));
      if ($urandom_range(9) != 0) f = f + $urandom_range(1, 1 << $urandom_range(0, 20));
      if (f > 32'hFFFFFF) f = 32'hFFFFFF;
    end
  endfunction

  function automatic void plan_phase(input int n);
    int made;
    int seg;
    logic [31:0] ra;
    logic [FREQ_W-1:0] lo, hi, q;
    made = 0;
    while (made < n) begin
      ra = $urandom;
      if ($urandom_range(99) < 8) begin
        plan_table();
        made += TABLE_SIZE;
      end else if ($urandom_range(99) < 12) begin
        request_backlog.push_back(write_item(ra[IDX_W-1:0], ra[31:8], 16'($urandom)));
        made++;
      end else begin
        if ($urandom_range(99) < 25) begin
          q = ra[FREQ_W-1:0];
        end else begin
          seg = $urandom_range(1, TABLE_SIZE - 1);
          lo = plan_freq[seg-1];
          hi = plan_freq[seg];
          case ($urandom_range(3))
            0: q = lo;
            1: q = hi;
            default: q = (hi > lo) ? lo + FREQ_W'($urandom_range(0, 32'(hi - lo))) : lo;
          endcase
        end
        request_backlog.push_back(query_item(q));
        made++;
      end
    end
  endfunction

  task automatic write_point_count(input logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_count = v;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_valid || expected_answers.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_answer(in_data);
      if (!in_valid || !in_stall) begin
        if (request_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else if (hold_start && hold_count == 0) begin
      out_stall <= 1'b1;
      hold_count <= HOLD_CYCLES;
    end else if (hold_count > 0) begin
      out_stall <= 1'b1;
      hold_count <= hold_count - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin : answer_check
    plc_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result correction=%0d is_answer=%0b",
                                out_data.correction, out_data.is_answer));
      end else begin
        e = expected_answers.pop_front();
        if (out_data.correction !== e.correction)
          flag_mismatch($sformatf("correction %0d, expected %0d",
                                  out_data.correction, e.correction));
        if (out_data.is_answer !== e.is_answer)
          flag_mismatch($sformatf("is_answer %0b, expected %0b",
                                  out_data.is_answer, e.is_answer));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("piecewise_linear_correction_lookup_tb failed");
    $finish;
  end

  initial begin
    model_freq = '{24'd10000, 24'd50000, 24'd100000, 24'd200000,
                   24'd300000, 24'd400000, 24'd500000, 24'd600000};
    for (int i = 0; i < TABLE_SIZE; i++) model_corr[i] = UNITY_CORR;
    model_count = 4'd8;
    plan_freq = model_freq;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_point_count(4'd8);
    request_backlog.push_back(query_item(24'd0));
    request_backlog.push_back(query_item(24'd10000));
    request_backlog.push_back(query_item(24'd75000));
    request_backlog.push_back(query_item(24'hFFFFFF));
    request_backlog.push_back(write_item(3'd0, 24'd0, 16'd0));
    request_backlog.push_back(write_item(3'd1, 24'd1, 16'hFFFF));
    request_backlog.push_back(query_item(24'd1));
    request_backlog.push_back(write_item(3'd2, 24'd3, 16'd0));
    request_backlog.push_back(query_item(24'd2));
    request_backlog.push_back(write_item(3'd7, 24'hFFFFFF, 16'hFFFF));
    request_backlog.push_back(write_item(3'd6, 24'd200000, 16'd0));
    request_backlog.push_back(query_item(24'hFFFFFF));
    request_backlog.push_back(query_item(24'h800000));
    request_backlog.push_back(query_item(24'd300001));
    request_backlog.push_back(query_item(24'd450000));
    request_backlog.push_back(write_item(3'd3, 24'hFFFFFF, 16'd1));
    request_backlog.push_back(query_item(24'hFFFFFF));
    request_backlog.push_back(query_item(24'd150000));
    request_backlog.push_back(query_item(24'd0));
    request_backlog.push_back(write_item(3'd4, 24'd0, 16'hFFFF));
    request_backlog.push_back(query_item(24'd5));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_point_count(COUNT_W'(PHASE_POINT_COUNT[p]));
      tx_idle_pct <= PHASE_TX_IDLE[p];
      rx_stall_pct <= PHASE_RX_STALL[p];
      plan_phase(ITEMS_PER_PHASE);
      if (p == 4) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("piecewise_linear_correction_lookup_tb passed");
    end else begin
      $display("piecewise_linear_correction_lookup_tb failed");
    end
    $finish;
  end

endmodule
